FILE: hw/rtl/mpp_pkg.sv
// ----------------------------------------------------------------------------
// mpp_pkg
// Shared types and constants of the multi-phase pattern PWM generator.
// ----------------------------------------------------------------------------
package mpp_pkg;

    // Register map, word index of each configuration register
    typedef enum logic [1:0] {
        REG_PERIOD = 2'd0,
        REG_PHASES = 2'd1,
        REG_WAVES  = 2'd2,
        REG_RUN    = 2'd3
    } mpp_reg_t;

    // Request kinds
    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    localparam int PERIOD_W = 24;
    localparam int PCOUNT_W = 5;
    localparam int WCOUNT_W = 4;
    localparam int POINT_W  = 17;
    localparam int PAT_W    = 8;
    localparam int PROD_W   = POINT_W + PERIOD_W;

    localparam logic [PERIOD_W-1:0] PERIOD_RST = 24'd1000;
    localparam logic [PCOUNT_W-1:0] PCOUNT_RST = 5'd2;
    localparam logic [WCOUNT_W-1:0] WCOUNT_RST = 4'd1;

    localparam logic [POINT_W-1:0]  POINT_ONE  = 17'h10000;
    localparam logic [PERIOD_W-1:0] POS_MAX    = 24'hFFFFFF;

    typedef struct packed {
        logic [PERIOD_W-1:0] period_ticks;
        logic [PCOUNT_W-1:0] phase_count;
        logic [WCOUNT_W-1:0] wave_count;
        logic                run_enable;
    } mpp_cfg_t;

endpackage

FILE: hw/rtl/mpp_if.sv
// ----------------------------------------------------------------------------
// mpp_if
// Request and result channels of the pattern PWM generator.
// ----------------------------------------------------------------------------
interface mpp_req_if #(
    parameter int IDX_W = 4
);
    logic                valid;
    logic                ready;
    logic                req_type;
    logic [IDX_W-1:0]    entry_index;
    logic [16:0]         entry_switch_point;
    logic [7:0]          entry_pin_pattern;

    modport source (
        output valid, req_type, entry_index, entry_switch_point, entry_pin_pattern,
        input  ready
    );
    modport sink (
        input  valid, req_type, entry_index, entry_switch_point, entry_pin_pattern,
        output ready
    );
endinterface

interface mpp_rsp_if #(
    parameter int WAVES = 8,
    parameter int IDX_W = 4
);
    logic                valid;
    logic                ready;
    logic [WAVES-1:0]    pin_levels;
    logic [IDX_W-1:0]    phase_now;
    logic                period_wrapped;

    modport source (
        output valid, pin_levels, phase_now, period_wrapped,
        input  ready
    );
    modport sink (
        input  valid, pin_levels, phase_now, period_wrapped,
        output ready
    );
endinterface

FILE: hw/rtl/mpp_cfg_regs.sv
// ----------------------------------------------------------------------------
// mpp_cfg_regs
// APB register file: period, phase count, wave count and run enable.
// ----------------------------------------------------------------------------
module mpp_cfg_regs (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output mpp_pkg::mpp_cfg_t cfg
);
    import mpp_pkg::*;

    mpp_cfg_t cfg_reg;
    mpp_reg_t sel;
    logic     wr_en;

    assign pready = 1'b1;
    assign sel    = mpp_reg_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.period_ticks <= PERIOD_RST;
            cfg_reg.phase_count  <= PCOUNT_RST;
            cfg_reg.wave_count   <= WCOUNT_RST;
            cfg_reg.run_enable   <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (sel)
                REG_PERIOD: cfg_reg.period_ticks <= pwdata[PERIOD_W-1:0];
                REG_PHASES: cfg_reg.phase_count  <= pwdata[PCOUNT_W-1:0];
                REG_WAVES:  cfg_reg.wave_count   <= pwdata[WCOUNT_W-1:0];
                REG_RUN:    cfg_reg.run_enable   <= pwdata[0];
            endcase
        end
    end

    always_comb
    begin
        unique case (sel)
            REG_PERIOD: prdata = 32'(cfg_reg.period_ticks);
            REG_PHASES: prdata = 32'(cfg_reg.phase_count);
            REG_WAVES:  prdata = 32'(cfg_reg.wave_count);
            REG_RUN:    prdata = 32'(cfg_reg.run_enable);
        endcase
    end

endmodule

FILE: hw/rtl/mpp_engine.sv
// ----------------------------------------------------------------------------
// mpp_engine
// Input register, phase tables, period state and result register.
// ----------------------------------------------------------------------------
module mpp_engine #(
    parameter int PHASES = 16,
    parameter int WAVES  = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  mpp_pkg::mpp_cfg_t cfg,
    mpp_req_if.sink           req,
    mpp_rsp_if.source         rsp
);
    import mpp_pkg::*;

    localparam int IDX_W     = $clog2(PHASES);
    localparam int CNT_W     = $clog2(PHASES + 1);
    localparam int WSEL_W    = $clog2(WAVES + 1);
    localparam int PAT_EXT_W = WAVES + PAT_W;

    // Input register
    logic                 in_valid_reg;
    logic                 in_type_reg;
    logic [IDX_W-1:0]     in_idx_reg;
    logic [POINT_W-1:0]   in_point_reg;
    logic [PAT_W-1:0]     in_pat_reg;

    // Phase tables
    logic [POINT_W-1:0]   point_tbl_reg [PHASES];
    logic [PAT_W-1:0]     pat_tbl_reg   [PHASES];

    // Period state
    logic [PERIOD_W-1:0]  pos_reg,   pos_next;
    logic [IDX_W-1:0]     phase_reg, phase_next;
    logic [WAVES-1:0]     pins_reg,  pins_next;
    logic                 wrap_next;

    // Result register
    logic                 out_valid_reg;
    logic [WAVES-1:0]     out_pins_reg;
    logic [IDX_W-1:0]     out_phase_reg;
    logic                 out_wrap_reg;

    logic                 advance;
    logic [CNT_W-1:0]     n_eff;
    logic [IDX_W-1:0]     last_ph;
    logic [IDX_W-1:0]     ph;
    logic [PERIOD_W-1:0]  pos_inc;
    logic [POINT_W-1:0]   point;
    logic [PERIOD_W-1:0]  per;
    logic [PROD_W-1:0]    prod;
    logic [PERIOD_W-1:0]  target;
    logic [WSEL_W-1:0]    w_eff;
    logic [PAT_EXT_W-1:0] pat_ext;
    logic [WAVES-1:0]     pat_masked;

    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            in_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_type_reg  <= req.req_type;
            in_idx_reg   <= req.entry_index;
            in_point_reg <= req.entry_switch_point;
            in_pat_reg   <= req.entry_pin_pattern;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && (in_type_reg == REQ_WRITE) && (int'(in_idx_reg) < PHASES))
        begin
            point_tbl_reg[in_idx_reg] <= in_point_reg;
            pat_tbl_reg[in_idx_reg]   <= in_pat_reg;
        end
    end

    // Clamp the configuration into its legal ranges
    always_comb
    begin
        if (int'(cfg.phase_count) < 2)
            n_eff = CNT_W'(2);
        else if (int'(cfg.phase_count) > PHASES)
            n_eff = CNT_W'(PHASES);
        else
            n_eff = CNT_W'(cfg.phase_count);

        if (cfg.wave_count == '0)
            w_eff = WSEL_W'(1);
        else if (int'(cfg.wave_count) > WAVES)
            w_eff = WSEL_W'(WAVES);
        else
            w_eff = WSEL_W'(cfg.wave_count);

        per = (cfg.period_ticks == '0) ? PERIOD_W'(1) : cfg.period_ticks;
    end

    assign last_ph = IDX_W'(n_eff - CNT_W'(1));
    assign ph      = (CNT_W'(phase_reg) >= n_eff) ? last_ph : phase_reg;
    assign pos_inc = (pos_reg == POS_MAX) ? POS_MAX : pos_reg + PERIOD_W'(1);
    assign point   = (point_tbl_reg[ph] > POINT_ONE) ? POINT_ONE : point_tbl_reg[ph];
    assign prod    = PROD_W'(point) * PROD_W'(per);
    assign target  = prod[PROD_W-2:16];
    assign pat_ext = PAT_EXT_W'(pat_tbl_reg[ph]);

    always_comb
    begin
        for (int i = 0; i < WAVES; i++)
        begin
            pat_masked[i] = pat_ext[i] && (i < int'(w_eff));
        end
    end

    // One tick while run is enabled: step the position, switch at most one phase
    always_comb
    begin
        pos_next   = pos_reg;
        phase_next = phase_reg;
        pins_next  = pins_reg;
        wrap_next  = 1'b0;
        if ((in_type_reg == REQ_TICK) && cfg.run_enable)
        begin
            pos_next   = pos_inc;
            phase_next = ph;
            if (pos_inc >= target)
            begin
                pins_next = pat_masked;
                if (ph == last_ph)
                begin
                    phase_next = '0;
                    pos_next   = '0;
                    wrap_next  = 1'b1;
                end
                else
                begin
                    phase_next = ph + IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            phase_reg     <= '0;
            pins_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                pos_reg   <= pos_next;
                phase_reg <= phase_next;
                pins_reg  <= pins_next;
            end
            if (advance)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_pins_reg  <= pins_next;
            out_phase_reg <= phase_next;
            out_wrap_reg  <= wrap_next;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.pin_levels     = out_pins_reg;
    assign rsp.phase_now      = out_phase_reg;
    assign rsp.period_wrapped = out_wrap_reg;

endmodule

FILE: hw/rtl/multi_phase_pattern_pwm.sv
// ----------------------------------------------------------------------------
// multi_phase_pattern_pwm
// Tick-driven generator of synchronized pin waves from a table of phases.
//
//   channel  | dir | transfer when        | payload
//   ---------+-----+----------------------+----------------------------------
//   req      | in  | valid && ready       | req_type, entry_index,
//            |     |                      | entry_switch_point, entry_pin_pattern
//   rsp      | out | valid && ready       | pin_levels, phase_now, period_wrapped
//   apb      | in  | psel&penable&pwrite  | paddr, pwdata (pready tied high)
//
// One request per cycle while rsp is taken; a result passes the input register,
// then the result register. The per-tick path is one table read, one 17x24
// multiply and one 24-bit compare.
// Reset clears position, phase and pins at once; the tables are not cleared.
// A stalled result holds; one more request waits in the input register,
// then req.ready drops until rsp is taken.
// ----------------------------------------------------------------------------
module multi_phase_pattern_pwm #(
    parameter int PHASES = 16,
    parameter int WAVES  = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    mpp_req_if.sink     req,
    mpp_rsp_if.source   rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mpp_pkg::*;

    mpp_cfg_t cfg;

    mpp_cfg_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mpp_engine #(
        .PHASES (PHASES),
        .WAVES  (WAVES)
    ) u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .req   (req),
        .rsp   (rsp)
    );

endmodule

FILE: hw/rtl/mpp_checker.sv
// ----------------------------------------------------------------------------
// mpp_checker
// Port-level checks of the pattern PWM generator, bound to the top level.
// ----------------------------------------------------------------------------
module mpp_checker #(
    parameter int WAVES = 8,
    parameter int IDX_W = 4
) (
    input logic             clk,
    input logic             rst_n,
    input logic             req_valid,
    input logic             req_ready,
    input logic             rsp_valid,
    input logic             rsp_ready,
    input logic [WAVES-1:0] pin_levels,
    input logic [IDX_W-1:0] phase_now,
    input logic             period_wrapped
);

    // Stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(pin_levels)
            && $stable(phase_now) && $stable(period_wrapped))
        else $error("stalled result changed");

    // Requests are refused only while a result is stalled
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> rsp_valid && !rsp_ready)
        else $error("request refused with free output");

    // A fresh result traces back to an earlier request transfer
    a_rsp_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
        else $error("result without request");

    // Closing a period returns to the first phase
    a_wrap_phase: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && period_wrapped |-> phase_now == '0)
        else $error("wrap without phase restart");

endmodule

bind multi_phase_pattern_pwm mpp_checker #(
    .WAVES (WAVES),
    .IDX_W ($clog2(PHASES))
) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .pin_levels     (rsp.pin_levels),
    .phase_now      (rsp.phase_now),
    .period_wrapped (rsp.period_wrapped)
);
